// File: design/gbss_pkg.sv
// Shared types, widths and index helpers for the scalar source block.
`default_nettype none
package gbss_pkg;

    localparam int IDX_W  = 2;
    localparam int VAL_W  = 32;
    localparam int OUT_W  = 64;
    localparam int MIX_W  = 64;
    localparam int ACC_W  = 128;
    localparam int LIMB_W = 32;
    localparam int PROD_W = 2 * (LIMB_W + 1);
    localparam int SH_W   = $clog2(ACC_W);
    localparam int PACK_W = 2 * IDX_W;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [1:0] {
        SRC_STORE,
        SRC_MIX,
        SRC_TRACE,
        SRC_KSCALE
    } t_src;

    typedef struct packed {
        logic       mac;
        logic       clear;
        logic       emit;
        logic       clr_tr;
        logic       load_tr2;
        t_src       src;
        t_idx       idx_a;
        t_idx       idx_b;
        t_idx       idx_d;
        logic [1:0] limb_a;
        logic       limb_b;
    } t_cmd;

    typedef struct packed {
        logic load;
        logic finish;
        t_cmd cmd;
    } t_ctl;

    typedef struct packed {
        logic out_busy;
    } t_stat;

    // Packed upper-triangle slot of a symmetric pair, in either index order.
    function automatic logic [PACK_W-1:0] pack_sym(input t_idx r, input t_idx c, input int dim);
        int lo;
        int hi;
        int p;
        lo = (r <= c) ? int'(r) : int'(c);
        hi = (r <= c) ? int'(c) : int'(r);
        p  = lo * dim - ((lo * (lo + 1)) >>> 1) + hi;
        return PACK_W'(p);
    endfunction

    function automatic logic [PACK_W-1:0] mix_index(input t_idx r, input t_idx c, input int dim);
        int p;
        p = int'(r) * dim + int'(c);
        return PACK_W'(p);
    endfunction

endpackage
`default_nettype wire

// File: design/gbss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gbss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// File: design/gbss_datapath.sv
// Datapath: component stores, shared limb multiplier, wide accumulator, result register.
`default_nettype none
module gbss_datapath #(
    parameter int SPACETIME_DIM = 4,
    parameter int FRAC_BITS     = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire gbss_pkg::t_ctl                    i_ctl,
    input  wire logic [gbss_pkg::IDX_W-1:0]        i_row_index,
    input  wire logic [gbss_pkg::IDX_W-1:0]        i_column_index,
    input  wire logic signed [gbss_pkg::VAL_W-1:0] i_stress_value,
    input  wire logic signed [gbss_pkg::VAL_W-1:0] i_metric_value,
    input  wire logic signed [gbss_pkg::VAL_W-1:0] i_electric_scalar,
    input  wire logic signed [gbss_pkg::VAL_W-1:0] i_magnetic_scalar,
    input  wire logic                              i_last_pair,
    input  wire logic                              i_out_stall,
    output gbss_pkg::t_stat                        o_stat,
    output logic                                   o_out_valid,
    output logic signed [gbss_pkg::OUT_W-1:0]      o_source_value,
    output logic                                   o_saturated
);

    localparam int ST_DEPTH = SPACETIME_DIM * (SPACETIME_DIM + 1) / 2;
    localparam int ST_AW    = $clog2(ST_DEPTH);
    localparam int MX_DEPTH = SPACETIME_DIM * SPACETIME_DIM;
    localparam int MX_AW    = $clog2(MX_DEPTH);
    localparam int ACC_W    = gbss_pkg::ACC_W;
    localparam int MIX_W    = gbss_pkg::MIX_W;
    localparam int LIMB_W   = gbss_pkg::LIMB_W;
    localparam int SH_W     = gbss_pkg::SH_W;
    localparam int OUT_W    = gbss_pkg::OUT_W;

    localparam logic [MIX_W-1:0] K_SCALE =
        ((64'd1 << (FRAC_BITS + 1)) + 64'd1) / 64'd3;
    localparam logic [ACC_W-1:0] RND_MIX = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [ACC_W-1:0] RND_OUT = ACC_W'(1) << (2 * FRAC_BITS - 1);
    localparam logic [SH_W-1:0]  SH_FRAC = SH_W'(FRAC_BITS + 1);

    // store write side
    logic                     st_wr_en;
    logic [ST_AW-1:0]         st_wr_addr;
    logic [gbss_pkg::IDX_W-1:0] hi_idx;

    // store and mix reads
    logic [ST_AW-1:0]         t_rd_addr;
    logic [ST_AW-1:0]         g_rd_addr;
    logic [MX_AW-1:0]         m_rd_addr;
    logic [gbss_pkg::VAL_W-1:0] t_rd;
    logic [gbss_pkg::VAL_W-1:0] g_rd;
    logic [MIX_W-1:0]         m_rd;
    logic [MIX_W-1:0]         mt_rd;

    // pipeline
    gbss_pkg::t_cmd           r_c1;
    gbss_pkg::t_cmd           r_c2;
    logic [ACC_W-1:0]         op_a;
    logic [MIX_W-1:0]         op_b;
    logic [LIMB_W-1:0]        limb_a;
    logic [LIMB_W-1:0]        limb_b;
    logic                     sign_a;
    logic                     sign_b;
    logic signed [LIMB_W:0]   mul_a;
    logic signed [LIMB_W:0]   mul_b;
    logic signed [gbss_pkg::PROD_W-1:0] r_pp;

    // accumulate stage
    logic [SH_W-1:0]          sh;
    logic                     is_mix;
    logic [ACC_W-1:0]         term;
    logic [ACC_W-1:0]         base;
    logic [ACC_W-1:0]         mac_sum;
    logic [ACC_W-1:0]         eterm;
    logic [ACC_W-1:0]         mix_sum;
    logic [MIX_W-1:0]         mix_val;
    logic [MX_AW-1:0]         m_wr_addr;
    logic [MX_AW-1:0]         mt_wr_addr;
    logic [ACC_W-1:0]         r_acc;
    logic [ACC_W-1:0]         r_tr2;
    logic [MIX_W-1:0]         r_tr;
    logic [gbss_pkg::IDX_W-1:0] r_grp_a;
    logic [gbss_pkg::IDX_W-1:0] r_grp_d;
    logic signed [gbss_pkg::VAL_W:0] r_ediff;

    // result
    logic [ACC_W-1:0]         fin_sum;
    logic [ACC_W-1:0]         fin_shift;
    logic                     fin_sat;
    logic [OUT_W-1:0]         fin_val;
    logic                     r_out_valid;
    logic [OUT_W-1:0]         r_source;
    logic                     r_sat;

    // ---------------- store load ----------------
    assign hi_idx     = (i_row_index <= i_column_index) ? i_column_index : i_row_index;
    assign st_wr_en   = i_ctl.load && (int'(hi_idx) < SPACETIME_DIM);
    assign st_wr_addr = ST_AW'(gbss_pkg::pack_sym(i_row_index, i_column_index, SPACETIME_DIM));

    assign t_rd_addr = ST_AW'(gbss_pkg::pack_sym(i_ctl.cmd.idx_a, i_ctl.cmd.idx_b,
                                                 SPACETIME_DIM));
    assign g_rd_addr = ST_AW'(gbss_pkg::pack_sym(i_ctl.cmd.idx_b, i_ctl.cmd.idx_d,
                                                 SPACETIME_DIM));
    assign m_rd_addr = MX_AW'(gbss_pkg::mix_index(i_ctl.cmd.idx_a, i_ctl.cmd.idx_d,
                                                  SPACETIME_DIM));

    gbss_ram #(.WIDTH(gbss_pkg::VAL_W), .DEPTH(ST_DEPTH)) u_stress (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (i_stress_value),
        .i_rd_addr (t_rd_addr),
        .o_rd_data (t_rd)
    );

    gbss_ram #(.WIDTH(gbss_pkg::VAL_W), .DEPTH(ST_DEPTH)) u_metric (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (i_metric_value),
        .i_rd_addr (g_rd_addr),
        .o_rd_data (g_rd)
    );

    // M and its transpose, so one address yields M[a][d] and M[d][a]
    gbss_ram #(.WIDTH(MIX_W), .DEPTH(MX_DEPTH)) u_mix (
        .i_clk     (i_clk),
        .i_wr_en   (r_c2.emit),
        .i_wr_addr (m_wr_addr),
        .i_wr_data (mix_val),
        .i_rd_addr (m_rd_addr),
        .o_rd_data (m_rd)
    );

    gbss_ram #(.WIDTH(MIX_W), .DEPTH(MX_DEPTH)) u_mix_t (
        .i_clk     (i_clk),
        .i_wr_en   (r_c2.emit),
        .i_wr_addr (mt_wr_addr),
        .i_wr_data (mix_val),
        .i_rd_addr (m_rd_addr),
        .o_rd_data (mt_rd)
    );

    // ---------------- multiply stage ----------------
    always_comb begin
        case (r_c1.src)
            gbss_pkg::SRC_STORE: begin
                op_a   = ACC_W'($signed(t_rd));
                op_b   = MIX_W'($signed(g_rd));
                sign_a = 1'b1;
                sign_b = 1'b1;
            end
            gbss_pkg::SRC_MIX: begin
                op_a   = ACC_W'($signed(m_rd));
                op_b   = mt_rd;
                sign_a = (r_c1.limb_a == 2'd1);
                sign_b = r_c1.limb_b;
            end
            gbss_pkg::SRC_TRACE: begin
                op_a   = ACC_W'($signed(r_tr));
                op_b   = r_tr;
                sign_a = (r_c1.limb_a == 2'd1);
                sign_b = r_c1.limb_b;
            end
            gbss_pkg::SRC_KSCALE: begin
                op_a   = r_tr2;
                op_b   = K_SCALE;
                sign_a = (r_c1.limb_a == 2'd3);
                sign_b = 1'b0;
            end
            default: begin
                op_a   = '0;
                op_b   = '0;
                sign_a = 1'b0;
                sign_b = 1'b0;
            end
        endcase
    end

    assign limb_a = op_a[r_c1.limb_a * LIMB_W +: LIMB_W];
    assign limb_b = op_b[r_c1.limb_b * LIMB_W +: LIMB_W];
    assign mul_a  = $signed({sign_a & limb_a[LIMB_W-1], limb_a});
    assign mul_b  = $signed({sign_b & limb_b[LIMB_W-1], limb_b});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
        end else begin
            r_c1 <= i_ctl.cmd;
            r_c2 <= r_c1;
        end
        r_pp <= mul_a * mul_b;
    end

    // ---------------- accumulate stage ----------------
    assign is_mix = (r_c2.src == gbss_pkg::SRC_MIX);
    assign sh     = ((SH_W'(r_c2.limb_a) + SH_W'(r_c2.limb_b)) << 5)
                  + SH_W'(is_mix && (r_c2.idx_a != r_c2.idx_d))
                  + (is_mix ? SH_FRAC : '0);
    assign term    = ACC_W'(r_pp) << sh;
    assign base    = r_c2.clear ? '0 : r_acc;
    assign mac_sum = is_mix ? (base - term) : (base + term);
    assign eterm   = ACC_W'(r_ediff) << (3 + 2 * FRAC_BITS);

    assign mix_sum    = r_acc + RND_MIX;
    assign mix_val    = mix_sum[FRAC_BITS +: MIX_W];
    assign m_wr_addr  = MX_AW'(gbss_pkg::mix_index(r_grp_a, r_grp_d, SPACETIME_DIM));
    assign mt_wr_addr = MX_AW'(gbss_pkg::mix_index(r_grp_d, r_grp_a, SPACETIME_DIM));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_last_pair) begin
            r_ediff <= (gbss_pkg::VAL_W + 1)'(i_electric_scalar)
                     - (gbss_pkg::VAL_W + 1)'(i_magnetic_scalar);
        end
        if (r_c2.mac) begin
            r_acc <= mac_sum;
        end else if (r_c2.load_tr2) begin
            r_acc <= eterm;
        end
        if (r_c2.load_tr2) begin
            r_tr2 <= r_acc;
        end
        if (r_c2.mac && r_c2.clear) begin
            r_grp_a <= r_c2.idx_a;
            r_grp_d <= r_c2.idx_d;
        end
        if (r_c2.clr_tr) begin
            r_tr <= '0;
        end else if (r_c2.emit && (r_grp_a == r_grp_d)) begin
            r_tr <= r_tr + mix_val;
        end
    end

    // ---------------- result ----------------
    assign fin_sum   = r_acc + RND_OUT;
    assign fin_shift = ACC_W'($signed(fin_sum) >>> (2 * FRAC_BITS));
    assign fin_sat   = (fin_shift[ACC_W-1:OUT_W] != {(ACC_W-OUT_W){fin_shift[OUT_W-1]}});
    assign fin_val   = fin_sat ? (fin_shift[ACC_W-1] ? gbss_pkg::OUT_MIN : gbss_pkg::OUT_MAX)
                               : fin_shift[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.finish) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_ctl.finish) begin
            r_source <= fin_val;
            r_sat    <= fin_sat;
        end
    end

    assign o_stat.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_source_value  = r_source;
    assign o_saturated     = r_sat;

endmodule
`default_nettype wire

// File: design/gbss_ctrl.sv
// Controller: input handshake and the command sequence for one point's evaluation.
`default_nettype none
module gbss_ctrl #(
    parameter int SPACETIME_DIM = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_last_pair,
    input  wire gbss_pkg::t_stat i_stat,
    output logic                 o_in_stall,
    output gbss_pkg::t_ctl       o_ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX,
        S_MIX_END,
        S_DRAIN,
        S_TR2,
        S_LOAD,
        S_KSCALE,
        S_SQ,
        S_FINISH
    } t_state;

    localparam gbss_pkg::t_idx LAST_IDX = gbss_pkg::t_idx'(SPACETIME_DIM - 1);

    t_state         r_state, n_state;
    t_state         r_after, n_after;
    logic           r_wait, n_wait;
    gbss_pkg::t_idx r_a, n_a;
    gbss_pkg::t_idx r_b, n_b;
    gbss_pkg::t_idx r_d, n_d;
    logic [1:0]     r_k, n_k;
    gbss_pkg::t_cmd r_cmd, n_cmd;
    logic           r_finish, n_finish;
    logic           r_stall, n_stall;
    logic           accept;

    assign accept = i_in_valid && !r_stall;

    always_comb begin
        n_state  = r_state;
        n_after  = r_after;
        n_wait   = r_wait;
        n_a      = r_a;
        n_b      = r_b;
        n_d      = r_d;
        n_k      = r_k;
        n_cmd    = '0;
        n_finish = 1'b0;
        n_stall  = r_stall;
        case (r_state)
            S_IDLE: begin
                if (accept && i_last_pair) begin
                    n_stall = 1'b1;
                    n_state = S_MIX;
                    n_a     = '0;
                    n_b     = '0;
                    n_d     = '0;
                end
            end
            S_MIX: begin
                n_cmd.mac    = 1'b1;
                n_cmd.clear  = (r_b == '0);
                n_cmd.emit   = (r_b == '0) && ((r_a != '0) || (r_d != '0));
                n_cmd.clr_tr = (r_b == '0) && (r_a == '0) && (r_d == '0);
                n_cmd.src    = gbss_pkg::SRC_STORE;
                n_cmd.idx_a  = r_a;
                n_cmd.idx_b  = r_b;
                n_cmd.idx_d  = r_d;
                if (r_b == LAST_IDX) begin
                    n_b = '0;
                    if (r_d == LAST_IDX) begin
                        n_d = '0;
                        if (r_a == LAST_IDX) begin
                            n_state = S_MIX_END;
                        end else begin
                            n_a = r_a + 1'b1;
                        end
                    end else begin
                        n_d = r_d + 1'b1;
                    end
                end else begin
                    n_b = r_b + 1'b1;
                end
            end
            S_MIX_END: begin
                n_cmd.emit = 1'b1;
                n_state    = S_DRAIN;
                n_after    = S_TR2;
                n_wait     = 1'b1;
                n_k        = '0;
            end
            S_DRAIN: begin
                if (!r_wait) begin
                    n_state = r_after;
                end else begin
                    n_wait = 1'b0;
                end
            end
            S_TR2: begin
                n_cmd.mac    = 1'b1;
                n_cmd.clear  = (r_k == 2'd0);
                n_cmd.src    = gbss_pkg::SRC_TRACE;
                n_cmd.limb_a = {1'b0, r_k[1]};
                n_cmd.limb_b = r_k[0];
                n_k          = r_k + 1'b1;
                if (r_k == 2'd3) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_cmd.load_tr2 = 1'b1;
                n_state        = S_DRAIN;
                n_after        = S_KSCALE;
                n_wait         = 1'b1;
                n_k            = '0;
            end
            S_KSCALE: begin
                n_cmd.mac    = 1'b1;
                n_cmd.src    = gbss_pkg::SRC_KSCALE;
                n_cmd.limb_a = r_k;
                n_k          = r_k + 1'b1;
                if (r_k == 2'd3) begin
                    n_state = S_SQ;
                    n_a     = '0;
                    n_d     = '0;
                end
            end
            S_SQ: begin
                n_cmd.mac    = 1'b1;
                n_cmd.src    = gbss_pkg::SRC_MIX;
                n_cmd.idx_a  = r_a;
                n_cmd.idx_d  = r_d;
                n_cmd.limb_a = {1'b0, r_k[1]};
                n_cmd.limb_b = r_k[0];
                n_k          = r_k + 1'b1;
                if (r_k == 2'd3) begin
                    if (r_d == LAST_IDX) begin
                        if (r_a == LAST_IDX) begin
                            n_state = S_DRAIN;
                            n_after = S_FINISH;
                            n_wait  = 1'b1;
                        end else begin
                            n_a = r_a + 1'b1;
                            n_d = r_a + 1'b1;
                        end
                    end else begin
                        n_d = r_d + 1'b1;
                    end
                end
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    n_finish = 1'b1;
                    n_stall  = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_after  <= S_IDLE;
            r_wait   <= 1'b0;
            r_a      <= '0;
            r_b      <= '0;
            r_d      <= '0;
            r_k      <= '0;
            r_cmd    <= '0;
            r_finish <= 1'b0;
            r_stall  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_after  <= n_after;
            r_wait   <= n_wait;
            r_a      <= n_a;
            r_b      <= n_b;
            r_d      <= n_d;
            r_k      <= n_k;
            r_cmd    <= n_cmd;
            r_finish <= n_finish;
            r_stall  <= n_stall;
        end
    end

    assign o_in_stall   = r_stall;
    assign o_ctl.load   = accept;
    assign o_ctl.finish = r_finish;
    assign o_ctl.cmd    = r_cmd;

endmodule
`default_nettype wire

// File: design/gauss_bonnet_scalar_source.sv
// Top level of the Gauss-Bonnet scalar source unit: controller plus datapath.
//
//  channel  direction  handshake                 word
//  in       input      i_in_valid / o_in_stall   row/column index, stress, metric, E, B, last
//  out      output     o_out_valid / i_out_stall source_value, saturated
//
// A word without last_pair is stored without stalling the input. A last word stalls the
// input while the single 33x33 multiplier forms M = T*g, trace(M)^2 and trace(M*M) in
// 32-bit limbs.
// Reset is synchronous, active low, and clears control only; the stores need no clearing.
// A held result on the output does not block input; the next result waits for it.
`default_nettype none
module gauss_bonnet_scalar_source #(
    parameter int SPACETIME_DIM = 4,
    parameter int FRAC_BITS     = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [gbss_pkg::IDX_W-1:0]        i_row_index,
    input  wire logic [gbss_pkg::IDX_W-1:0]        i_column_index,
    input  wire logic signed [gbss_pkg::VAL_W-1:0] i_stress_value,
    input  wire logic signed [gbss_pkg::VAL_W-1:0] i_metric_value,
    input  wire logic signed [gbss_pkg::VAL_W-1:0] i_electric_scalar,
    input  wire logic signed [gbss_pkg::VAL_W-1:0] i_magnetic_scalar,
    input  wire logic                              i_last_pair,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [gbss_pkg::OUT_W-1:0]      o_source_value,
    output logic                                   o_saturated
);

    gbss_pkg::t_ctl  ctl;
    gbss_pkg::t_stat stat;

    gbss_ctrl #(
        .SPACETIME_DIM (SPACETIME_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_pair (i_last_pair),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_ctl       (ctl)
    );

    gbss_datapath #(
        .SPACETIME_DIM (SPACETIME_DIM),
        .FRAC_BITS     (FRAC_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .i_row_index       (i_row_index),
        .i_column_index    (i_column_index),
        .i_stress_value    (i_stress_value),
        .i_metric_value    (i_metric_value),
        .i_electric_scalar (i_electric_scalar),
        .i_magnetic_scalar (i_magnetic_scalar),
        .i_last_pair       (i_last_pair),
        .i_out_stall       (i_out_stall),
        .o_stat            (stat),
        .o_out_valid       (o_out_valid),
        .o_source_value    (o_source_value),
        .o_saturated       (o_saturated)
    );

endmodule
`default_nettype wire
